>>> hdl/stq_pkg.sv
// shared types for the sequenced ticket ring queue
// holds the opcode codes, the slot record and the controller/datapath handshake structs
// no dependencies
package stq_pkg;

   // operation codes carried by an item
   typedef enum logic [2:0] {
      OP_RESERVE  = 3'd0,
      OP_PUBLISH  = 3'd1,
      OP_CONSUME  = 3'd2,
      OP_RELEASE  = 3'd3,
      OP_COMPLETE = 3'd4,
      OP_QUERY    = 3'd5
   } opcode_type;

   // one stored slot record
   typedef struct packed {
      logic [31:0] seq;
      logic [31:0] ticket;
      logic [31:0] request;
      logic        done;
   } slot_type;

   // commands from controller to datapath
   typedef struct packed {
      logic clear;  // write the reset record at the sweep address
      logic load;   // capture the item and issue the slot read
      logic exec;   // update slot and counters, load the result register
   } dp_cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic clear_last;  // sweep is at the final slot
   } dp_status_type;

endpackage

>>> hdl/sequenced_ticket_ring_queue_top.sv
// Sequenced ticket ring queue manager. Each item is one operation (reserve, publish,
// consume, release, mark complete, query) on a ring of RING_DEPTH slots, and each item
// gives exactly one result. An item first reads the slot record from the single-port
// slot memory and then writes it back and loads the result register, and the block
// takes no new item until the previous one is written back; a new item is taken while the
// previous result still waits on rsp_stall. After reset the block sweeps the slot
// memory to its initial contents, one slot per cycle, and holds req_stall high until
// the sweep ends. A reserve or consume whose slot is not ready answers busy and
// leaves the head or tail unchanged. RING_DEPTH should be a power of two.
// depends on stq_pkg, stq_ctrl, stq_datapath
module sequenced_ticket_ring_queue_top
   import stq_pkg::*;
#(
   parameter int RING_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_opcode,
   input  logic [3:0]  req_slot_index,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_status,
   output logic [3:0]  rsp_granted_slot,
   output logic [31:0] rsp_ticket,
   output logic [31:0] rsp_request_id,
   output logic        rsp_done_flag
);

   dp_cmd_type    cmd;
   dp_status_type status;

   // sequencing
   stq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   // slot storage and arithmetic
   stq_datapath #(
      .RING_DEPTH (RING_DEPTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_opcode       (req_opcode),
      .req_slot_index   (req_slot_index),
      .rsp_status       (rsp_status),
      .rsp_granted_slot (rsp_granted_slot),
      .rsp_ticket       (rsp_ticket),
      .rsp_request_id   (rsp_request_id),
      .rsp_done_flag    (rsp_done_flag)
   );

endmodule

>>> hdl/stq_ctrl.sv
// controller for the sequenced ticket ring queue
// sequences the clearing sweep, item capture and slot update; owns rsp_valid
// depends on stq_pkg
module stq_ctrl
   import stq_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output dp_cmd_type    cmd,
   input  dp_status_type status
);

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      can_load;

   // result register may take a new item when empty or being drained
   assign can_load = !rsp_valid_ff || !rsp_stall;

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd          = '0;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (can_load) begin
               cmd.exec     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

>>> hdl/stq_datapath.sv
// datapath for the sequenced ticket ring queue
// slot memory, head/tail/request counters, slot update logic and result register
// depends on stq_pkg
module stq_datapath
   import stq_pkg::*;
#(
   parameter int RING_DEPTH = 16
) (
   input  logic          clock,
   input  logic          reset,
   input  dp_cmd_type    cmd,
   output dp_status_type status,
   input  logic [2:0]    req_opcode,
   input  logic [3:0]    req_slot_index,
   output logic          rsp_status,
   output logic [3:0]    rsp_granted_slot,
   output logic [31:0]   rsp_ticket,
   output logic [31:0]   rsp_request_id,
   output logic          rsp_done_flag
);

   localparam int IDX_W = $clog2(RING_DEPTH);
   localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(RING_DEPTH - 1);
   localparam logic [31:0] DEPTH_WORD = 32'(RING_DEPTH);

   // reduce a 4-bit slot index modulo the depth by repeated subtraction
   function automatic logic [IDX_W-1:0] reduce_index(input logic [3:0] idx);
      logic [3:0]       v;
      logic [IDX_W+3:0] wide;
      v = idx;
      for (int i = 0; i < 8; i++) begin
         if (32'(v) >= DEPTH_WORD) begin
            v = v - 4'(RING_DEPTH);
         end
      end
      wide = {{IDX_W{1'b0}}, v};
      return wide[IDX_W-1:0];
   endfunction

   // next slot pointer, kept in step with a 32-bit counter that wraps
   function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] slot,
                                                  input logic [31:0] count);
      if (count == '1 || slot == LAST_SLOT) begin
         return '0;
      end
      return slot + 1'b1;
   endfunction

   slot_type slot_mem [RING_DEPTH];

   logic [IDX_W-1:0] clear_addr_ff;
   logic [31:0]      head_count_ff, tail_count_ff, next_req_ff;
   logic [IDX_W-1:0] head_slot_ff, tail_slot_ff;
   opcode_type       op_ff;
   logic [IDX_W-1:0] addr_ff, rd_addr;
   slot_type         rd_data_ff;
   slot_type         new_slot;
   logic             busy;
   logic             head_step, tail_step;
   logic [IDX_W+3:0] addr_ext;

   logic             rsp_status_ff;
   logic [3:0]       rsp_granted_slot_ff;
   logic [31:0]      rsp_ticket_ff, rsp_request_id_ff;
   logic             rsp_done_flag_ff;

   assign status.clear_last = (clear_addr_ff == LAST_SLOT);

   // slot addressed by the incoming item
   always_comb begin
      case (opcode_type'(req_opcode))
         OP_RESERVE: rd_addr = head_slot_ff;
         OP_CONSUME: rd_addr = tail_slot_ff;
         default:    rd_addr = reduce_index(req_slot_index);
      endcase
   end

   // slot update and counter steps
   always_comb begin
      new_slot  = rd_data_ff;
      busy      = 1'b0;
      head_step = 1'b0;
      tail_step = 1'b0;
      case (op_ff)
         OP_RESERVE: begin
            if (rd_data_ff.seq == head_count_ff) begin
               new_slot.ticket  = head_count_ff;
               new_slot.request = next_req_ff;
               new_slot.done    = 1'b0;
               head_step        = 1'b1;
            end else begin
               busy = 1'b1;
            end
         end
         OP_PUBLISH: begin
            new_slot.seq = rd_data_ff.ticket + 32'd1;
         end
         OP_CONSUME: begin
            if (rd_data_ff.seq == tail_count_ff + 32'd1) begin
               tail_step = 1'b1;
            end else begin
               busy = 1'b1;
            end
         end
         OP_RELEASE: begin
            new_slot.seq = rd_data_ff.ticket + DEPTH_WORD;
         end
         OP_COMPLETE: begin
            new_slot.done = 1'b1;
         end
         default: begin
            new_slot = rd_data_ff;
         end
      endcase
   end

   // slot memory: sweep writes after reset, write-back on execute, registered read
   always_ff @(posedge clock) begin
      if (cmd.clear) begin
         slot_mem[clear_addr_ff] <= '{seq: 32'(clear_addr_ff), ticket: '0,
                                      request: '0, done: 1'b0};
      end else if (cmd.exec) begin
         slot_mem[addr_ff] <= new_slot;
      end
      if (cmd.load) begin
         rd_data_ff <= slot_mem[rd_addr];
      end
   end

   // sweep address and queue counters
   always_ff @(posedge clock) begin
      if (reset) begin
         clear_addr_ff <= '0;
         head_count_ff <= '0;
         tail_count_ff <= '0;
         head_slot_ff  <= '0;
         tail_slot_ff  <= '0;
         next_req_ff   <= 32'd1;
      end else begin
         if (cmd.clear) begin
            clear_addr_ff <= clear_addr_ff + 1'b1;
         end
         if (cmd.exec && head_step) begin
            head_count_ff <= head_count_ff + 32'd1;
            head_slot_ff  <= next_slot(head_slot_ff, head_count_ff);
            next_req_ff   <= next_req_ff + 32'd1;
         end
         if (cmd.exec && tail_step) begin
            tail_count_ff <= tail_count_ff + 32'd1;
            tail_slot_ff  <= next_slot(tail_slot_ff, tail_count_ff);
         end
      end
   end

   // item capture
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff   <= opcode_type'(req_opcode);
         addr_ff <= rd_addr;
      end
   end

   assign addr_ext = {4'b0, addr_ff};

   // result register
   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         rsp_status_ff       <= busy;
         rsp_granted_slot_ff <= addr_ext[3:0];
         rsp_ticket_ff       <= new_slot.ticket;
         rsp_request_id_ff   <= new_slot.request;
         rsp_done_flag_ff    <= new_slot.done;
      end
   end

   assign rsp_status       = rsp_status_ff;
   assign rsp_granted_slot = rsp_granted_slot_ff;
   assign rsp_ticket       = rsp_ticket_ff;
   assign rsp_request_id   = rsp_request_id_ff;
   assign rsp_done_flag    = rsp_done_flag_ff;

endmodule
